/* rtl/hard_iron_compass_heading_core_macros.svh */
// ----------------------------------------------------------------------------
// Compass heading core assertion macros
// Shared assertion wrappers for the heading core RTL.
// ----------------------------------------------------------------------------
`ifndef HARD_IRON_COMPASS_HEADING_CORE_MACROS_SVH
`define HARD_IRON_COMPASS_HEADING_CORE_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define HICH_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the core clock and reset.
`define HICH_ASSERT(label, prop, msg) \
    `HICH_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

/* rtl/hich_pkg.sv */
// ----------------------------------------------------------------------------
// Compass heading package
// Shared types, constants and table functions for the heading core.
// ----------------------------------------------------------------------------
package hich_pkg;

    localparam int ATAN_DEPTH = 24;
    localparam int IDX_W      = 5;
    localparam int RAW_W      = 16;
    localparam int AXIS_W     = 17;
    localparam int VEC_W      = 28;
    localparam int ANG_W      = 22;
    localparam int ANG16_W    = 14;
    localparam int CFG_W      = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int SUM_W      = 16;
    localparam int HEAD_W     = 9;
    localparam int CARD_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_DECL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UOFS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK = 2'd2;

    localparam logic signed [ANG_W-1:0]  ANG_180   = 22'sd737280;
    localparam logic signed [ANG_W-1:0]  ANG_ROUND = 22'sd128;
    localparam logic signed [SUM_W-1:0]  FULL_TURN = 16'sd5760;
    localparam logic signed [AXIS_W-1:0] LOW_INIT  = 17'sd32768;
    localparam logic signed [AXIS_W-1:0] HIGH_INIT = -17'sd32768;

    typedef struct packed {
        logic                      done;
        logic signed [ANG16_W-1:0] angle;
    } t_cordic_res;

    // atan(2^-i) in 1/4096 degree
    function automatic logic [17:0] atan_q12(input logic [IDX_W-1:0] idx);
        logic [17:0] v;
        case (idx)
            5'd0:    v = 18'd184320;
            5'd1:    v = 18'd108810;
            5'd2:    v = 18'd57492;
            5'd3:    v = 18'd29184;
            5'd4:    v = 18'd14649;
            5'd5:    v = 18'd7331;
            5'd6:    v = 18'd3667;
            5'd7:    v = 18'd1833;
            5'd8:    v = 18'd917;
            5'd9:    v = 18'd458;
            5'd10:   v = 18'd229;
            5'd11:   v = 18'd115;
            5'd12:   v = 18'd57;
            5'd13:   v = 18'd29;
            5'd14:   v = 18'd14;
            5'd15:   v = 18'd7;
            5'd16:   v = 18'd4;
            5'd17:   v = 18'd2;
            5'd18:   v = 18'd1;
            default: v = 18'd0;
        endcase
        return v;
    endfunction

    // 45-degree sectors centered on N, NE, ... ; boundaries at 45k-22.5
    function automatic logic [CARD_W-1:0] sector_of(input logic [HEAD_W-1:0] h);
        logic [3:0] k;
        k = 4'd0;
        for (int j = 1; j <= 8; j++) begin
            if (h >= HEAD_W'(45 * j - 22)) k = k + 4'd1;
        end
        return k[CARD_W-1:0];
    endfunction

endpackage

/* rtl/hich_sample_if.sv */
// ----------------------------------------------------------------------------
// Magnetometer sample channel
// Valid/ready channel carrying one raw X/Y sample and its arrival flag.
// ----------------------------------------------------------------------------
interface hich_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] x_raw;
    logic [15:0] y_raw;
    logic        sample_ok;

    modport source (output valid, output x_raw, output y_raw, output sample_ok,
                    input ready);
    modport sink   (input valid, input x_raw, input y_raw, input sample_ok,
                    output ready);
endinterface

/* rtl/hich_heading_if.sv */
// ----------------------------------------------------------------------------
// Heading result channel
// Valid/ready channel carrying one heading result.
// ----------------------------------------------------------------------------
interface hich_heading_if;
    logic               valid;
    logic               ready;
    logic [8:0]         heading_deg;
    logic [2:0]         cardinal;
    logic               heading_error;
    logic signed [16:0] centered_x;
    logic signed [16:0] centered_y;

    modport source (output valid, output heading_deg, output cardinal,
                    output heading_error, output centered_x, output centered_y,
                    input ready);
    modport sink   (input valid, input heading_deg, input cardinal,
                    input heading_error, input centered_x, input centered_y,
                    output ready);
endinterface

/* rtl/hich_cordic.sv */
// ----------------------------------------------------------------------------
// Iterative vectoring CORDIC
// One shared add/shift stage, one micro-rotation per cycle; gives atan2(y, x)
// in 1/16 degree, rounded from a 1/4096 degree accumulator.
// ----------------------------------------------------------------------------
module hich_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [hich_pkg::AXIS_W-1:0]    i_cx,
    input  logic signed [hich_pkg::AXIS_W-1:0]    i_cy,
    output hich_pkg::t_cordic_res                 o_res
);

    localparam int VW = hich_pkg::VEC_W;
    localparam int AW = hich_pkg::ANG_W;
    localparam int IW = hich_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(CORDIC_STEPS - 1);

    logic                  r_busy;
    logic                  r_round;
    logic                  r_done;
    logic [IW-1:0]         r_idx;
    logic signed [VW-1:0]  r_vx;
    logic signed [VW-1:0]  r_vy;
    logic signed [AW-1:0]  r_vz;
    logic signed [hich_pkg::ANG16_W-1:0] r_angle;

    logic signed [VW-1:0]  n_vx;
    logic signed [VW-1:0]  n_vy;
    logic signed [AW-1:0]  n_vz;
    logic signed [VW-1:0]  c_x0;
    logic signed [VW-1:0]  c_y0;
    logic signed [VW-1:0]  c_sx;
    logic signed [VW-1:0]  c_sy;
    logic [AW-1:0]         c_atan;
    logic signed [AW-1:0]  c_zr;
    logic                  c_neg;
    logic                  c_zero;

    assign c_x0   = {{(VW - hich_pkg::AXIS_W - 8){i_cx[hich_pkg::AXIS_W-1]}}, i_cx, 8'd0};
    assign c_y0   = {{(VW - hich_pkg::AXIS_W - 8){i_cy[hich_pkg::AXIS_W-1]}}, i_cy, 8'd0};
    assign c_neg  = i_cx[hich_pkg::AXIS_W-1];
    assign c_zero = (i_cx == '0) && (i_cy == '0);

    assign c_sx   = r_vy >>> r_idx;
    assign c_sy   = r_vx >>> r_idx;
    assign c_atan = AW'(hich_pkg::atan_q12(r_idx));
    assign c_zr   = r_vz + hich_pkg::ANG_ROUND;

    always_comb begin
        if (!r_vy[VW-1]) begin
            n_vx = r_vx + c_sx;
            n_vy = r_vy - c_sy;
            n_vz = r_vz + $signed(c_atan);
        end else begin
            n_vx = r_vx - c_sx;
            n_vy = r_vy + c_sy;
            n_vz = r_vz - $signed(c_atan);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= 1'b0;
            r_done  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_done  <= 1'b0;
            r_round <= 1'b0;
            if (i_start) begin
                r_idx <= '0;
                if (c_zero) begin
                    r_done  <= 1'b1;
                    r_angle <= '0;
                end else begin
                    r_busy <= 1'b1;
                    r_vx   <= c_neg ? -c_x0 : c_x0;
                    r_vy   <= c_neg ? -c_y0 : c_y0;
                    r_vz   <= c_neg ? hich_pkg::ANG_180 : '0;
                end
            end else if (r_busy) begin
                r_vx  <= n_vx;
                r_vy  <= n_vy;
                r_vz  <= n_vz;
                r_idx <= r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    r_busy  <= 1'b0;
                    r_round <= 1'b1;
                end
            end else if (r_round) begin
                r_angle <= c_zr[AW-1:8];
                r_done  <= 1'b1;
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.angle = r_angle;

endmodule

/* rtl/hard_iron_compass_heading_core.sv */
// ----------------------------------------------------------------------------
// Hard-iron calibrated compass heading core
// Tracks per-axis min/max, centers X/Y, finds atan2 by CORDIC, adds
// declination and trim, wraps to [0,360) and gives an eight-way sector.
//
//  channel     dir  handshake      payload
//  i_sample    in   valid/ready    x_raw, y_raw, sample_ok
//  o_heading   out  valid/ready    heading_deg, cardinal, heading_error,
//                                  centered_x, centered_y
//  i_cfg_*     in   write enable   index, 14-bit data
//
// Each sample holds the core from its transfer through centering, launch,
// CORDIC_STEPS micro-rotations on the single add/shift stage, a rounding
// step, the sum and the wrap steps. A zero vector skips the rotations; a missing
// sample goes straight to the output stage. i_sample.ready
// is high only between samples. A finished result waits in the output register
// while the next sample is taken; a stall there holds the core in its last state.
// Reset is synchronous and clears bounds, config and handshake state.
// ----------------------------------------------------------------------------
`include "hard_iron_compass_heading_core_macros.svh"

module hard_iron_compass_heading_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    hich_sample_if.sink                          i_sample,
    hich_heading_if.source                       o_heading,
    input  logic                                 i_cfg_we,
    input  logic [hich_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [hich_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int AXW = hich_pkg::AXIS_W;
    localparam int SW  = hich_pkg::SUM_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CENTER = 3'd1;
    localparam logic [2:0] S_LAUNCH = 3'd2;
    localparam logic [2:0] S_CORDIC = 3'd3;
    localparam logic [2:0] S_SUM    = 3'd4;
    localparam logic [2:0] S_WRAP   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]                   r_state;
    logic [hich_pkg::CFG_W-1:0]   r_decl;
    logic [hich_pkg::CFG_W-1:0]   r_uofs;
    logic                         r_lock;
    logic signed [AXW-1:0]        r_xlo;
    logic signed [AXW-1:0]        r_xhi;
    logic signed [AXW-1:0]        r_ylo;
    logic signed [AXW-1:0]        r_yhi;
    logic signed [AXW-1:0]        r_x;
    logic signed [AXW-1:0]        r_y;
    logic signed [AXW-1:0]        r_cx;
    logic signed [AXW-1:0]        r_cy;
    logic                         r_err;
    logic signed [SW-1:0]         r_total;
    logic                         r_out_valid;
    logic [hich_pkg::HEAD_W-1:0]  r_out_head;
    logic [hich_pkg::CARD_W-1:0]  r_out_card;
    logic                         r_out_err;
    logic signed [AXW-1:0]        r_out_cx;
    logic signed [AXW-1:0]        r_out_cy;

    logic                         c_accept;
    logic signed [AXW-1:0]        c_xs;
    logic signed [AXW-1:0]        c_ys;
    logic signed [AXW:0]          c_xsum;
    logic signed [AXW:0]          c_ysum;
    logic signed [AXW:0]          c_xmid;
    logic signed [AXW:0]          c_ymid;
    logic signed [AXW:0]          c_cx;
    logic signed [AXW:0]          c_cy;
    logic [hich_pkg::HEAD_W-1:0]  c_head;
    logic                         c_out_free;
    logic                         c_err_zero;
    hich_pkg::t_cordic_res        c_res;

    assign c_accept   = i_sample.valid && i_sample.ready;
    assign c_out_free = !r_out_valid || o_heading.ready;

    // offset binary to signed: flip the top bit, sign-extend
    assign c_xs = {~i_sample.x_raw[15], ~i_sample.x_raw[15], i_sample.x_raw[14:0]};
    assign c_ys = {~i_sample.y_raw[15], ~i_sample.y_raw[15], i_sample.y_raw[14:0]};

    // center = (lo + hi) / 2 toward zero
    assign c_xsum = (AXW+1)'(r_xlo) + (AXW+1)'(r_xhi);
    assign c_ysum = (AXW+1)'(r_ylo) + (AXW+1)'(r_yhi);
    assign c_xmid = (c_xsum + $signed((AXW+1)'(c_xsum[AXW]))) >>> 1;
    assign c_ymid = (c_ysum + $signed((AXW+1)'(c_ysum[AXW]))) >>> 1;
    assign c_cx   = (AXW+1)'(r_x) - c_xmid;
    assign c_cy   = (AXW+1)'(r_y) - c_ymid;

    assign c_head = r_total[hich_pkg::HEAD_W+3:4];

    hich_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_LAUNCH),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .o_res   (c_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl <= '0;
            r_uofs <= '0;
            r_lock <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hich_pkg::REG_DECL: r_decl <= i_cfg_data;
                hich_pkg::REG_UOFS: r_uofs <= i_cfg_data;
                hich_pkg::REG_LOCK: r_lock <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_err       <= 1'b0;
            r_xlo       <= hich_pkg::LOW_INIT;
            r_xhi       <= hich_pkg::HIGH_INIT;
            r_ylo       <= hich_pkg::LOW_INIT;
            r_yhi       <= hich_pkg::HIGH_INIT;
        end else begin
            if (r_out_valid && o_heading.ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (c_accept) begin
                        r_x   <= c_xs;
                        r_y   <= c_ys;
                        r_err <= !i_sample.sample_ok;
                        if (i_sample.sample_ok) begin
                            r_state <= S_CENTER;
                            if (!r_lock) begin
                                if (c_xs < r_xlo) r_xlo <= c_xs;
                                if (c_xs > r_xhi) r_xhi <= c_xs;
                                if (c_ys < r_ylo) r_ylo <= c_ys;
                                if (c_ys > r_yhi) r_yhi <= c_ys;
                            end
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_CENTER: begin
                    r_cx    <= c_cx[AXW-1:0];
                    r_cy    <= c_cy[AXW-1:0];
                    r_state <= S_LAUNCH;
                end
                S_LAUNCH: begin
                    r_state <= S_CORDIC;
                end
                S_CORDIC: begin
                    if (c_res.done) r_state <= S_SUM;
                end
                S_SUM: begin
                    r_total <= SW'(c_res.angle) + SW'($signed(r_decl))
                             + SW'($signed(r_uofs));
                    r_state <= S_WRAP;
                end
                S_WRAP: begin
                    if (r_total[SW-1]) begin
                        r_total <= r_total + hich_pkg::FULL_TURN;
                    end else if (r_total >= hich_pkg::FULL_TURN) begin
                        r_total <= r_total - hich_pkg::FULL_TURN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (c_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_err   <= r_err;
                        if (r_err) begin
                            r_out_head <= '0;
                            r_out_card <= '0;
                            r_out_cx   <= '0;
                            r_out_cy   <= '0;
                        end else begin
                            r_out_head <= c_head;
                            r_out_card <= hich_pkg::sector_of(c_head);
                            r_out_cx   <= r_cx;
                            r_out_cy   <= r_cy;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_sample.ready          = (r_state == S_IDLE);
    assign o_heading.valid         = r_out_valid;
    assign o_heading.heading_deg   = r_out_head;
    assign o_heading.cardinal      = r_out_card;
    assign o_heading.heading_error = r_out_err;
    assign o_heading.centered_x    = r_out_cx;
    assign o_heading.centered_y    = r_out_cy;

    assign c_err_zero = (r_out_head == '0) && (r_out_card == '0);

    `HICH_ASSERT(a_accept_leaves_idle, c_accept |=> (r_state != S_IDLE), "sample not started")
    `HICH_ASSERT(a_cordic_done_waited, c_res.done |-> (r_state == S_CORDIC), "early CORDIC done")
    `HICH_ASSERT(a_heading_range, r_out_valid |-> (r_out_head <= 9'd359), "heading out of range")
    `HICH_ASSERT(a_error_zero, (r_out_valid && r_out_err) |-> c_err_zero, "error result not zero")

endmodule
